[rtl/core/lsfp_pkg.sv]
package lsfp_pkg;

    localparam int PACKETS_PER_FRAME = 60;
    localparam int PKT_W             = 6;
    localparam int OFF_W             = 6;
    localparam int SUB_W             = 3;
    localparam int ANGLE_W           = 9;
    localparam int WORD_W            = 16;
    localparam int XY_W              = 17;
    localparam int COUNT_W           = 6;
    localparam int SPEED_W           = 22;
    localparam int TRIG_FRAC_BITS_DEFAULT = 15;

    localparam logic [7:0] SYNC_FIRST  = 8'hFA;
    localparam logic [7:0] SYNC_SECOND = 8'hA0;

    // Byte offsets inside one 42-byte packet.
    localparam logic [OFF_W-1:0] OFF_HDR0     = 6'd0;
    localparam logic [OFF_W-1:0] OFF_HDR1     = 6'd1;
    localparam logic [OFF_W-1:0] OFF_SPD_LO   = 6'd2;
    localparam logic [OFF_W-1:0] OFF_SPD_HI   = 6'd3;
    localparam logic [OFF_W-1:0] OFF_RD_FIRST = 6'd4;
    localparam logic [OFF_W-1:0] OFF_RD_LAST  = 6'd39;
    localparam logic [OFF_W-1:0] OFF_LAST     = 6'd41;

    // Byte positions inside one 6-byte reading.
    localparam logic [SUB_W-1:0] SUB_INT_LO = 3'd0;
    localparam logic [SUB_W-1:0] SUB_INT_HI = 3'd1;
    localparam logic [SUB_W-1:0] SUB_RNG_LO = 3'd2;
    localparam logic [SUB_W-1:0] SUB_RNG_HI = 3'd3;
    localparam logic [SUB_W-1:0] SUB_LAST   = 3'd5;

    localparam logic [PKT_W-1:0] LAST_PKT = PKT_W'(PACKETS_PER_FRAME - 1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC,
        PH_FRAME
    } phase_t;

    // One parsed result on its way to the trig stage.
    typedef struct packed {
        logic                 valid;
        logic                 is_point;
        logic                 frame_end;
        logic [ANGLE_W-1:0]   angle_deg;
        logic [WORD_W-1:0]    range_mm;
        logic [WORD_W-1:0]    intensity;
        logic [COUNT_W-1:0]   good_packets;
        logic [SPEED_W-1:0]   speed_sum;
    } event_t;

    // round(65536 * sin(d degrees)) for d = 0..90.
    function automatic logic [16:0] quarter_sine(input logic [6:0] idx);
        logic [16:0] v;
        case (idx)
            7'd0: v = 17'd0;         7'd1: v = 17'd1144;      7'd2: v = 17'd2287;
            7'd3: v = 17'd3430;      7'd4: v = 17'd4572;      7'd5: v = 17'd5712;
            7'd6: v = 17'd6850;      7'd7: v = 17'd7987;      7'd8: v = 17'd9121;
            7'd9: v = 17'd10252;     7'd10: v = 17'd11380;    7'd11: v = 17'd12505;
            7'd12: v = 17'd13626;    7'd13: v = 17'd14742;    7'd14: v = 17'd15855;
            7'd15: v = 17'd16962;    7'd16: v = 17'd18064;    7'd17: v = 17'd19161;
            7'd18: v = 17'd20252;    7'd19: v = 17'd21336;    7'd20: v = 17'd22415;
            7'd21: v = 17'd23486;    7'd22: v = 17'd24550;    7'd23: v = 17'd25607;
            7'd24: v = 17'd26656;    7'd25: v = 17'd27697;    7'd26: v = 17'd28729;
            7'd27: v = 17'd29753;    7'd28: v = 17'd30767;    7'd29: v = 17'd31772;
            7'd30: v = 17'd32768;    7'd31: v = 17'd33754;    7'd32: v = 17'd34729;
            7'd33: v = 17'd35693;    7'd34: v = 17'd36647;    7'd35: v = 17'd37590;
            7'd36: v = 17'd38521;    7'd37: v = 17'd39441;    7'd38: v = 17'd40348;
            7'd39: v = 17'd41243;    7'd40: v = 17'd42126;    7'd41: v = 17'd42995;
            7'd42: v = 17'd43852;    7'd43: v = 17'd44695;    7'd44: v = 17'd45525;
            7'd45: v = 17'd46341;    7'd46: v = 17'd47143;    7'd47: v = 17'd47930;
            7'd48: v = 17'd48703;    7'd49: v = 17'd49461;    7'd50: v = 17'd50203;
            7'd51: v = 17'd50931;    7'd52: v = 17'd51643;    7'd53: v = 17'd52339;
            7'd54: v = 17'd53020;    7'd55: v = 17'd53684;    7'd56: v = 17'd54332;
            7'd57: v = 17'd54963;    7'd58: v = 17'd55578;    7'd59: v = 17'd56175;
            7'd60: v = 17'd56756;    7'd61: v = 17'd57319;    7'd62: v = 17'd57865;
            7'd63: v = 17'd58393;    7'd64: v = 17'd58903;    7'd65: v = 17'd59396;
            7'd66: v = 17'd59870;    7'd67: v = 17'd60326;    7'd68: v = 17'd60764;
            7'd69: v = 17'd61183;    7'd70: v = 17'd61584;    7'd71: v = 17'd61966;
            7'd72: v = 17'd62328;    7'd73: v = 17'd62672;    7'd74: v = 17'd62997;
            7'd75: v = 17'd63303;    7'd76: v = 17'd63589;    7'd77: v = 17'd63856;
            7'd78: v = 17'd64104;    7'd79: v = 17'd64332;    7'd80: v = 17'd64540;
            7'd81: v = 17'd64729;    7'd82: v = 17'd64898;    7'd83: v = 17'd65048;
            7'd84: v = 17'd65177;    7'd85: v = 17'd65287;    7'd86: v = 17'd65376;
            7'd87: v = 17'd65446;    7'd88: v = 17'd65496;    7'd89: v = 17'd65526;
            7'd90: v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/lidar_scan_frame_parser.sv]
// Byte-serial frame parser for a rotating lidar. It accepts one byte per clock,
// hunts for the sync pair 0xFA 0xA0, then walks a frame of 60 packets of 42
// bytes, giving one point beat per reading of a packet with a good header and
// a frame-end beat (good packet count and speed sum) at the last byte. A byte
// enters in every cycle that the output side is not stalled; a result passes
// through the parser register, the trig multiply register and the output
// register in turn. capture_enable low drops bytes and returns the parser to
// sync hunting.
module lidar_scan_frame_parser #(
    parameter int TRIG_FRAC_BITS = lsfp_pkg::TRIG_FRAC_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,    // [7:0] data_byte
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data,   // capture_enable
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [103:0]    m_tdata,    // angle_deg, range_mm, intensity, x_mm, y_mm,
                                        // good_packets, speed_sum, zero fill
    output logic [1:0]      m_tuser     // is_point, frame_end
);
    import lsfp_pkg::*;

    logic               capture_reg;
    logic               advance;
    logic               accept;
    event_t             ev_parse, ev_trig;
    logic [XY_W-1:0]    x_mm, y_mm;
    logic               m_tvalid_reg;
    logic [103:0]       tdata_reg;
    logic [1:0]         tuser_reg;

    assign advance   = !m_tvalid_reg || m_tready;
    assign s_tready  = advance;
    assign accept    = s_tvalid && advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capture_reg <= 1'b0;
        else if (cfg_valid)
            capture_reg <= cfg_data;
    end

    lsfp_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .accept         (accept),
        .data_byte      (s_tdata),
        .capture_enable (capture_reg),
        .ev             (ev_parse)
    );

    lsfp_trig #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .ev_in   (ev_parse),
        .ev_out  (ev_trig),
        .x_mm    (x_mm),
        .y_mm    (y_mm)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (advance)
            m_tvalid_reg <= ev_trig.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tdata_reg <= {1'b0, ev_trig.speed_sum, ev_trig.good_packets, y_mm, x_mm,
                          ev_trig.intensity, ev_trig.range_mm, ev_trig.angle_deg};
            tuser_reg <= {ev_trig.frame_end, ev_trig.is_point};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

[rtl/core/lsfp_parser.sv]
module lsfp_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                capture_enable,
    output lsfp_pkg::event_t    ev
);
    import lsfp_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [PKT_W-1:0]       pkt_reg, pkt_next;
    logic [OFF_W-1:0]       off_reg, off_next;
    logic [2:0]             rd_reg, rd_next;
    logic [SUB_W-1:0]       sub_reg, sub_next;
    logic                   good_reg, good_next;
    logic [7:0]             low_reg, low_next;
    logic [WORD_W-1:0]      int_reg, int_next;
    logic [COUNT_W-1:0]     cnt_reg, cnt_next;
    logic [SPEED_W-1:0]     speed_reg, speed_next;
    event_t                 ev_reg, ev_next;
    logic [ANGLE_W-1:0]     pkt_ext;
    logic [7:0]             hdr_expect;

    assign pkt_ext    = ANGLE_W'(pkt_reg);
    assign hdr_expect = SYNC_SECOND + 8'(pkt_reg);

    always_comb
    begin
        phase_next = phase_reg;
        pkt_next   = pkt_reg;
        off_next   = off_reg;
        rd_next    = rd_reg;
        sub_next   = sub_reg;
        good_next  = good_reg;
        low_next   = low_reg;
        int_next   = int_reg;
        cnt_next   = cnt_reg;
        speed_next = speed_reg;
        ev_next    = '0;

        if (accept)
        begin
            if (!capture_enable)
            begin
                phase_next = PH_HUNT;
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (data_byte == SYNC_FIRST)
                            phase_next = PH_SYNC;
                    end
                    PH_SYNC:
                    begin
                        if (data_byte == SYNC_SECOND)
                        begin
                            phase_next = PH_FRAME;
                            pkt_next   = '0;
                            off_next   = OFF_SPD_LO;
                            good_next  = 1'b1;
                            cnt_next   = COUNT_W'(1);
                            speed_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_FRAME:
                    begin
                        case (off_reg)
                            OFF_HDR0: good_next = (data_byte == SYNC_FIRST);
                            OFF_HDR1:
                            begin
                                good_next = good_reg && (data_byte == hdr_expect);
                                if (good_next)
                                    cnt_next = cnt_reg + COUNT_W'(1);
                            end
                            OFF_SPD_LO: low_next = data_byte;
                            OFF_SPD_HI:
                            begin
                                if (good_reg)
                                    speed_next = speed_reg + SPEED_W'({data_byte, low_reg});
                                rd_next  = '0;
                                sub_next = SUB_INT_LO;
                            end
                            default:
                            begin
                                if (off_reg inside {[OFF_RD_FIRST:OFF_RD_LAST]})
                                begin
                                    case (sub_reg)
                                        SUB_INT_LO, SUB_RNG_LO: low_next = data_byte;
                                        SUB_INT_HI: int_next = {data_byte, low_reg};
                                        SUB_RNG_HI:
                                        begin
                                            if (good_reg)
                                            begin
                                                ev_next.valid     = 1'b1;
                                                ev_next.is_point  = 1'b1;
                                                ev_next.angle_deg = (pkt_ext << 2)
                                                    + (pkt_ext << 1) + ANGLE_W'(rd_reg);
                                                ev_next.range_mm  = {data_byte, low_reg};
                                                ev_next.intensity = int_reg;
                                            end
                                        end
                                        default: ;
                                    endcase
                                    if (sub_reg == SUB_LAST)
                                    begin
                                        sub_next = SUB_INT_LO;
                                        rd_next  = rd_reg + 3'd1;
                                    end
                                    else
                                    begin
                                        sub_next = sub_reg + SUB_W'(1);
                                    end
                                end
                            end
                        endcase

                        if (off_reg == OFF_LAST)
                        begin
                            off_next = '0;
                            pkt_next = pkt_reg + PKT_W'(1);
                        end
                        else
                        begin
                            off_next = off_reg + OFF_W'(1);
                        end

                        // The last byte of the frame closes it, whatever it holds.
                        if (off_reg == OFF_LAST && pkt_reg == LAST_PKT)
                        begin
                            ev_next              = '0;
                            ev_next.valid        = 1'b1;
                            ev_next.frame_end    = 1'b1;
                            ev_next.good_packets = cnt_reg;
                            ev_next.speed_sum    = speed_reg;
                            phase_next           = PH_HUNT;
                        end
                    end
                    default: phase_next = PH_HUNT;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pkt_reg   <= '0;
            off_reg   <= '0;
            rd_reg    <= '0;
            sub_reg   <= '0;
            good_reg  <= 1'b0;
            low_reg   <= '0;
            int_reg   <= '0;
            cnt_reg   <= '0;
            speed_reg <= '0;
            ev_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pkt_reg   <= pkt_next;
            off_reg   <= off_next;
            rd_reg    <= rd_next;
            sub_reg   <= sub_next;
            good_reg  <= good_next;
            low_reg   <= low_next;
            int_reg   <= int_next;
            cnt_reg   <= cnt_next;
            speed_reg <= speed_next;
            ev_reg    <= ev_next;
        end
    end

    assign ev = ev_reg;

endmodule

[rtl/core/lsfp_trig.sv]
module lsfp_trig #(
    parameter int TRIG_FRAC_BITS = lsfp_pkg::TRIG_FRAC_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  lsfp_pkg::event_t            ev_in,
    output lsfp_pkg::event_t            ev_out,
    output logic [lsfp_pkg::XY_W-1:0]   x_mm,
    output logic [lsfp_pkg::XY_W-1:0]   y_mm
);
    import lsfp_pkg::*;

    localparam int CW    = TRIG_FRAC_BITS + 1;
    localparam int PW    = WORD_W + CW;
    localparam int SHIFT = 16 - TRIG_FRAC_BITS;
    localparam int TRND  = (SHIFT == 0) ? 0 : (1 << (SHIFT - 1));
    localparam logic [PW-1:0] PRND = PW'(1) << (TRIG_FRAC_BITS - 1);

    // Sign (top bit) and magnitude of sin(a) at TRIG_FRAC_BITS; a runs up to 449.
    function automatic logic [CW:0] sine_mag(input logic [9:0] a);
        logic [9:0]  a2;
        logic [9:0]  idx;
        logic        neg;
        logic [17:0] t;
        a2  = (a >= 10'd360) ? a - 10'd360 : a;
        neg = 1'b0;
        if (a2 <= 10'd90)
            idx = a2;
        else if (a2 <= 10'd180)
            idx = 10'd180 - a2;
        else if (a2 <= 10'd270)
        begin
            idx = a2 - 10'd180;
            neg = 1'b1;
        end
        else
        begin
            idx = 10'd360 - a2;
            neg = 1'b1;
        end
        t = (18'(quarter_sine(idx[6:0])) + 18'(TRND)) >> SHIFT;
        return {neg, t[CW-1:0]};
    endfunction

    logic [CW:0]    cos_s, sin_s;
    logic [PW-1:0]  px_reg, py_reg;
    logic           nx_reg, ny_reg;
    event_t         ev_reg;
    logic [PW-1:0]  rx, ry;
    logic [XY_W-1:0] mx, my;

    assign cos_s = sine_mag(10'(ev_in.angle_deg) + 10'd90);
    assign sin_s = sine_mag(10'(ev_in.angle_deg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= '0;
        end
        else if (advance)
        begin
            ev_reg <= ev_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg <= PW'(ev_in.range_mm) * PW'(cos_s[CW-1:0]);
            py_reg <= PW'(ev_in.range_mm) * PW'(sin_s[CW-1:0]);
            nx_reg <= cos_s[CW];
            ny_reg <= sin_s[CW];
        end
    end

    assign rx = px_reg + PRND;
    assign ry = py_reg + PRND;
    assign mx = rx[PW-1:TRIG_FRAC_BITS];
    assign my = ry[PW-1:TRIG_FRAC_BITS];

    always_comb
    begin
        x_mm = '0;
        y_mm = '0;
        if (ev_reg.is_point)
        begin
            x_mm = nx_reg ? (XY_W'(0) - mx) : mx;
            y_mm = ny_reg ? (XY_W'(0) - my) : my;
        end
    end

    assign ev_out = ev_reg;

endmodule
